// ----- rtl/core/csic_pkg.sv -----
// shared types and constants for the chi-square inverse covariance block
package csic_pkg;

  // default matrix side and vector length after reset
  localparam int MAX_DIM_DEF = 64;
  localparam int VL_W        = 7;
  localparam logic [VL_W-1:0] VL_RESET = 7'd64;

  // fixed point fraction bits of the Q16.16 operands
  localparam int FRAC_BITS = 16;

  // item modes
  localparam logic MODE_MATRIX = 1'b0;
  localparam logic MODE_DATA   = 1'b1;

  // input item
  typedef struct packed {
    logic              mode;
    logic [5:0]        row;
    logic [5:0]        column;
    logic signed [31:0] value;
    logic signed [31:0] mean_value;
  } data_t;

  // result item
  typedef struct packed {
    logic signed [63:0] chi_square;
    logic               overflow;
  } result_t;

  // finished row sum handed to the term unit
  typedef struct packed {
    logic               valid;
    logic               last;
    logic signed [63:0] h;
    logic signed [31:0] d;
  } term_in_t;

  // accumulator control for the term unit
  typedef struct packed {
    logic clear;
    logic init_sat;
  } term_ctl_t;

endpackage

// ----- rtl/core/chi_square_inverse_covariance.sv -----
// top level: squared mahalanobis distance d'Cd over a ring of difference cells
// matrix writes and non-final data items leave busy low.
// the final data item of a vector raises busy while the sequencer makes one matrix
// read per cycle from the matrix memory and the term pipeline drains.
// done is high for one cycle with the result; the receiver cannot stall it.
// rst is synchronous: length returns to 64, element index and flags clear.
module chi_square_inverse_covariance #(
  parameter int MAX_DIM = csic_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  csic_pkg::data_t               data,
  output logic                          done,
  output csic_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csic_pkg::VL_W-1:0]     cfg_data
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state;

  logic [csic_pkg::VL_W-1:0] vector_length;
  logic [IW-1:0]             len_m1;
  logic [IW-1:0]             element_index;
  logic                      saturation_seen;

  logic                      accept;
  logic                      mat_wr;
  logic                      dat_wr;
  logic                      trigger;
  logic signed [32:0]        diff_w;
  logic                      diff_sat;
  logic [31:0]               diff_q;
  logic [AW-1:0]             wr_addr;

  logic [31:0]               mem [MAX_DIM*MAX_DIM];
  logic [31:0]               rd_q;
  logic [AW-1:0]             rd_addr;

  logic [IW-1:0]             i_cnt;
  logic [IW-1:0]             j_cnt;
  logic [AW-1:0]             row_base;
  logic                      run;
  logic                      row_end;

  logic [31:0]               cell_q [MAX_DIM];
  logic [31:0]               head;
  logic [31:0]               di_cur;
  logic [31:0]               di_latch;

  logic                      v1, first1, last1, final1;
  logic signed [31:0]        d1, di1;
  logic                      v2, first2, last2, final2;
  logic signed [63:0]        p2;
  logic signed [31:0]        di2;
  logic signed [63:0]        h_acc;
  logic signed [63:0]        h_sum;

  csic_pkg::term_in_t        term_in;
  csic_pkg::term_ctl_t       term_ctl;

  // handshakes
  assign busy      = state != ST_IDLE;
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;
  assign mat_wr    = accept & (data.mode == csic_pkg::MODE_MATRIX)
                     & (int'(data.row) < MAX_DIM) & (int'(data.column) < MAX_DIM);
  assign dat_wr    = accept & (data.mode == csic_pkg::MODE_DATA);
  assign trigger   = dat_wr & (element_index >= len_m1);

  // effective length minus one
  always_comb begin
    if (vector_length == '0) begin
      len_m1 = '0;
    end else if (int'(vector_length) > MAX_DIM) begin
      len_m1 = IW'(MAX_DIM - 1);
    end else begin
      len_m1 = IW'(vector_length - 7'd1);
    end
  end

  // saturated difference
  assign diff_w   = 33'(data.value) - 33'(data.mean_value);
  assign diff_sat = diff_w[32] != diff_w[31];
  assign diff_q   = diff_sat ? (diff_w[32] ? 32'h8000_0000 : 32'h7fff_ffff) : diff_w[31:0];

  assign wr_addr = AW'(int'(data.row) * MAX_DIM + int'(data.column));

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= csic_pkg::VL_RESET;
    end else if (cfg_valid & cfg_ready) begin
      vector_length <= cfg_data;
    end
  end

  // element index and per-vector saturation flag
  always_ff @(posedge clk) begin
    if (rst) begin
      element_index   <= '0;
      saturation_seen <= 1'b0;
    end else if (trigger) begin
      element_index   <= '0;
      saturation_seen <= 1'b0;
    end else if (dat_wr) begin
      element_index   <= element_index + 1'b1;
      saturation_seen <= saturation_seen | diff_sat;
    end
  end

  // sequencer over rows and columns
  assign run     = state == ST_RUN;
  assign row_end = j_cnt == len_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (trigger) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (row_end && (i_cnt == len_m1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (trigger) begin
      i_cnt    <= '0;
      j_cnt    <= '0;
      row_base <= '0;
    end else if (run) begin
      if (row_end) begin
        j_cnt    <= '0;
        i_cnt    <= i_cnt + 1'b1;
        row_base <= row_base + AW'(MAX_DIM);
      end else begin
        j_cnt <= j_cnt + 1'b1;
      end
    end
  end

  // matrix memory
  assign rd_addr = row_base + AW'(j_cnt);

  always_ff @(posedge clk) begin
    if (mat_wr) begin
      mem[wr_addr] <= data.value;
    end
    if (run) begin
      rd_q <= mem[rd_addr];
    end
  end

  // ring of difference cells, rotating over the active length
  assign head = cell_q[0];

  for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
    logic [31:0] nbr;
    if (k == MAX_DIM - 1) begin : g_end
      assign nbr = cell_q[0];
    end else begin : g_mid
      assign nbr = cell_q[k+1];
    end
    csic_cell u_cell (
      .clk        (clk),
      .shift_en   (run & (IW'(k) <= len_m1)),
      .wrap       (IW'(k) == len_m1),
      .next_q     (nbr),
      .head_q     (head),
      .load       (dat_wr & (element_index == IW'(k))),
      .load_value (diff_q),
      .q          (cell_q[k])
    );
  end

  // row difference d_i passes the head when column equals row
  assign di_cur = (j_cnt == i_cnt) ? head : di_latch;

  always_ff @(posedge clk) begin
    if (run) begin
      di_latch <= di_cur;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= run;
      v2 <= v1;
    end
  end

  // product pipeline
  always_ff @(posedge clk) begin
    first1 <= j_cnt == '0;
    last1  <= row_end;
    final1 <= row_end & (i_cnt == len_m1);
    d1     <= head;
    di1    <= di_cur;
    first2 <= first1;
    last2  <= last1;
    final2 <= final1;
    p2     <= $signed(rd_q) * d1;
    di2    <= di1;
  end

  // row sum h_i of floored products
  assign h_sum = (first2 ? 64'sd0 : h_acc) + (p2 >>> csic_pkg::FRAC_BITS);

  always_ff @(posedge clk) begin
    if (v2) begin
      h_acc <= h_sum;
    end
  end

  assign term_in.valid = v2 & last2;
  assign term_in.last  = final2;
  assign term_in.h     = h_sum;
  assign term_in.d     = di2;

  assign term_ctl.clear    = trigger;
  assign term_ctl.init_sat = saturation_seen | diff_sat;

  csic_term u_term (
    .clk    (clk),
    .rst    (rst),
    .ctl    (term_ctl),
    .row_in (term_in),
    .done   (done),
    .result (result)
  );

endmodule

// ----- rtl/core/csic_cell.sv -----
// one difference cell of the rotating difference ring
module csic_cell (
  input  logic        clk,
  input  logic        shift_en,
  input  logic        wrap,
  input  logic [31:0] next_q,
  input  logic [31:0] head_q,
  input  logic        load,
  input  logic [31:0] load_value,
  output logic [31:0] q
);

  // load a new difference or take the neighbor's value while rotating
  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_value;
    end else if (shift_en) begin
      q <= wrap ? head_q : next_q;
    end
  end

endmodule

// ----- rtl/core/csic_term.sv -----
// row term d_i * h_i with saturation and the saturating running total
module csic_term (
  input  logic                clk,
  input  logic                rst,
  input  csic_pkg::term_ctl_t ctl,
  input  csic_pkg::term_in_t  row_in,
  output logic                done,
  output csic_pkg::result_t   result
);

  logic               a_v, a_last;
  logic signed [63:0] a_h;
  logic signed [31:0] a_d;

  logic               b_v, b_last;
  logic signed [64:0] b_plo;
  logic signed [31:0] b_hi;
  logic signed [31:0] b_d;

  logic               c_v, c_last;
  logic signed [64:0] c_plo;
  logic signed [63:0] c_phi;

  logic               d_v, d_last;
  logic signed [79:0] d_q;

  logic               e_v, e_last, e_sat;
  logic signed [63:0] e_term;

  logic signed [64:0] plo_c;
  logic signed [63:0] phi_c;
  logic signed [95:0] full_c;
  logic               fits_c;
  logic signed [64:0] sum_c;
  logic               add_ovf_c;

  logic signed [63:0] total;
  logic               sat;

  // low half of h times d
  assign plo_c = $signed({1'b0, a_h[31:0]}) * a_d;
  // high half of h times d
  assign phi_c = b_hi * b_d;
  // recombine the partial products
  assign full_c = $signed({c_phi, 32'd0}) + 96'(c_plo);
  // floored quotient fits in 64 bits
  assign fits_c = (&d_q[79:63]) | ~(|d_q[79:63]);
  // running sum with one guard bit
  assign sum_c     = 65'(total) + 65'(e_term);
  assign add_ovf_c = sum_c[64] != sum_c[63];

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      done <= 1'b0;
    end else begin
      a_v <= row_in.valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v;
      done <= e_v & e_last;
    end
  end

  // multiply pipeline payload
  always_ff @(posedge clk) begin
    a_last <= row_in.last;
    a_h    <= row_in.h;
    a_d    <= row_in.d;
    b_last <= a_last;
    b_plo  <= plo_c;
    b_hi   <= a_h[63:32];
    b_d    <= a_d;
    c_last <= b_last;
    c_plo  <= b_plo;
    c_phi  <= phi_c;
    d_last <= c_last;
    d_q    <= full_c[95:csic_pkg::FRAC_BITS];
    e_last <= d_last;
    if (fits_c) begin
      e_term <= d_q[63:0];
      e_sat  <= 1'b0;
    end else begin
      e_term <= d_q[79] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      e_sat  <= 1'b1;
    end
  end

  // saturating accumulation of the terms
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      total <= '0;
      sat   <= ctl.init_sat;
    end else if (e_v) begin
      if (add_ovf_c) begin
        total <= sum_c[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        total <= sum_c[63:0];
      end
      sat <= sat | e_sat | add_ovf_c;
    end
  end

  assign result.chi_square = total;
  assign result.overflow   = sat;

endmodule

// ----- bench/testbench.sv -----
// self-checking testbench for the chi-square inverse covariance block
`timescale 1ns / 1ps

module testbench;

  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam int     SIDE        = csic_pkg::MAX_DIM_DEF;
  // corner of the matrix that gets written; no length used reaches past it
  localparam int     TEST_SIDE   = 16;
  localparam int     LW          = csic_pkg::VL_W;
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -64'sd2147483648;
  localparam longint I64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN     = 64'sh8000_0000_0000_0000;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  csic_pkg::data_t     data;
  logic                done;
  csic_pkg::result_t   result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LW-1:0]       cfg_data;

  // own copy of the block state
  logic [31:0]         cov_mem [0:SIDE*SIDE-1];
  logic [31:0]         diff_mem [0:SIDE-1];
  int unsigned         elem_idx;
  bit                  sat_seen;
  logic [LW-1:0]       len_reg;
  csic_pkg::result_t   distance_fifo [$];

  int errors;
  int cycles;
  int calm_left;
  int items_sent;
  int matrix_items;
  int data_items;
  int distance_count;
  int overflow_count;
  int lengths_written;

  chi_square_inverse_covariance dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .data      (data),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic void note_error(input string what, input logic [63:0] want,
                                     input logic [63:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch at cycle %0d: %s expected %h got %h", cycles, what, want, got);
  endfunction

  // length as the block applies it: 0 acts as 1, above the side acts as the side
  function automatic int unsigned eff_length();
    if (len_reg == 0) return 1;
    if (len_reg > SIDE) return SIDE;
    return len_reg;
  endfunction

  // update the state for one accepted item, queue a distance when a vector completes
  function automatic void distance_step(input csic_pkg::data_t it);
    longint              dif;
    longint              h;
    longint              term;
    logic signed [127:0] prod;
    logic [64:0]         acc;
    logic [63:0]         total;
    int unsigned         n;
    int unsigned         idx;
    int unsigned         i;
    int unsigned         j;
    bit                  ovf;
    csic_pkg::result_t   want;
    if (it.mode == csic_pkg::MODE_MATRIX) begin
      cov_mem[{it.row, it.column}] = it.value;
      matrix_items++;
      return;
    end
    data_items++;
    // saturated difference into the current slot
    dif = longint'($signed(it.value)) - longint'($signed(it.mean_value));
    if (dif > Q_MAX) begin
      dif = Q_MAX;
      sat_seen = 1'b1;
    end
    if (dif < Q_MIN) begin
      dif = Q_MIN;
      sat_seen = 1'b1;
    end
    n = eff_length();
    idx = (elem_idx >= SIDE) ? SIDE - 1 : elem_idx;
    diff_mem[idx] = dif[31:0];
    if (idx + 1 < n) begin
      elem_idx = idx + 1;
      return;
    end
    // quadratic form: row sums, then saturated terms and saturated total
    ovf = sat_seen;
    total = '0;
    for (i = 0; i < n; i++) begin
      h = 0;
      for (j = 0; j < n; j++)
        h += (longint'($signed(cov_mem[i*SIDE+j])) * longint'($signed(diff_mem[j]))) >>> 16;
      prod = h;
      prod = prod * $signed(diff_mem[i]);
      prod = prod >>> 16;
      if (prod[127:63] != {65{prod[127]}}) begin
        term = prod[127] ? I64_MIN : I64_MAX;
        ovf = 1'b1;
      end else begin
        term = prod[63:0];
      end
      acc = {total[63], total} + {term[63], term};
      if (acc[64] != acc[63]) begin
        total = acc[64] ? I64_MIN : I64_MAX;
        ovf = 1'b1;
      end else begin
        total = acc[63:0];
      end
    end
    want.chi_square = total;
    want.overflow = ovf;
    distance_fifo.push_back(want);
    distance_count++;
    if (ovf) overflow_count++;
    elem_idx = 0;
    sat_seen = 1'b0;
  endfunction

  // result checker
  always @(posedge clk) begin
    csic_pkg::result_t want;
    if (!rst && done) begin
      if (distance_fifo.size() == 0) begin
        note_error("result with nothing pending, chi_square", '0, result.chi_square);
      end else begin
        want = distance_fifo.pop_front();
        if (result.chi_square !== want.chi_square)
          note_error("chi_square", want.chi_square, result.chi_square);
        if (result.overflow !== want.overflow)
          note_error("overflow", 64'(want.overflow), 64'(result.overflow));
      end
    end
  end

  // Q16.16 value: extremes, full range or small magnitudes
  function automatic logic [31:0] rand_q16();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5, 6, 7: return $urandom;
      default: return int'($urandom_range(0, 524288)) - 262144;
    endcase
  endfunction

  function automatic csic_pkg::data_t data_item(input logic [31:0] v, input logic [31:0] m);
    csic_pkg::data_t it;
    it.mode = csic_pkg::MODE_DATA;
    it.row = 6'($urandom);
    it.column = 6'($urandom);
    it.value = v;
    it.mean_value = m;
    return it;
  endfunction

  function automatic csic_pkg::data_t entry_item(input int r, input int c,
                                                 input logic [31:0] v);
    csic_pkg::data_t it;
    it.mode = csic_pkg::MODE_MATRIX;
    it.row = 6'(r);
    it.column = 6'(c);
    it.value = v;
    it.mean_value = $urandom;
    return it;
  endfunction

  // send one item with a random lead-in gap, occasional runs without gaps
  task automatic push_item(input csic_pkg::data_t it);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    data <= it;
    do @(posedge clk); while (busy);
    distance_step(it);
    items_sent++;
  endtask

  // hold the sender until every pending distance is out and the block is idle
  task automatic wait_drained(input int extra);
    start <= 1'b0;
    @(posedge clk);
    while (distance_fifo.size() != 0 || busy) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_length(input logic [LW-1:0] v);
    wait_drained(16);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_reg = v;
    lengths_written++;
  endtask

  function automatic logic [LW-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 12) return LW'(TEST_SIDE);
    if (r < 25) return LW'($urandom_range(9, TEST_SIDE));
    return LW'($urandom_range(1, 8));
  endfunction

  // every entry of the tested corner gets written so that no read hits an empty entry
  task automatic test_fill_matrix();
    int r;
    int c;
    for (r = 0; r < TEST_SIDE; r++)
      for (c = 0; c < TEST_SIDE; c++)
        push_item(entry_item(r, c, rand_q16()));
  endtask

  // first vector spans the whole tested corner and fills the first TEST_SIDE difference slots
  task automatic test_full_vector();
    int k;
    write_length(TEST_SIDE);
    for (k = 0; k < TEST_SIDE; k++)
      push_item(data_item(rand_q16(), rand_q16()));
  endtask

  // length zero, which acts as one, and length one
  task automatic test_length_extremes();
    write_length(0);
    push_item(data_item(32'h0001_8000, 32'hFFFF_0000));
    write_length(1);
    push_item(data_item(32'h7FFF_FFFF, 32'h0000_0001));
  endtask

  // differences saturating both ways, then a clean vector to see the flag clear
  task automatic test_difference_saturation();
    write_length(3);
    push_item(data_item(32'h7FFF_FFFF, 32'h8000_0000));
    push_item(data_item(32'h8000_0000, 32'h7FFF_FFFF));
    push_item(data_item(32'h7FFF_FFFF, 32'h0000_0000));
    push_item(data_item(32'h0002_0000, 32'h0001_0000));
    push_item(data_item(32'hFFFF_0000, 32'h0000_8000));
    push_item(data_item(32'h0000_0000, 32'h0000_0000));
  endtask

  // most negative entries and differences: each term lands exactly on the
  // 64-bit minimum, and the running sum saturates
  task automatic test_sum_saturation();
    int r;
    int c;
    int k;
    write_length(4);
    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++)
        push_item(entry_item(r, c, 32'h8000_0000));
    for (k = 0; k < 4; k++)
      push_item(data_item(32'h8000_0000, 32'h0000_0000));
  endtask

  // length lowered below the element index ends the vector on the next item
  task automatic test_length_lowered();
    int k;
    write_length(6);
    for (k = 0; k < 4; k++)
      push_item(data_item(rand_q16(), rand_q16()));
    write_length(2);
    push_item(data_item(rand_q16(), rand_q16()));
    push_item(data_item(rand_q16(), rand_q16()));
    push_item(data_item(rand_q16(), rand_q16()));
  endtask

  // length raised mid-vector, with a matrix write that must not move the index
  task automatic test_length_raised();
    int k;
    write_length(2);
    push_item(data_item(rand_q16(), rand_q16()));
    write_length(5);
    push_item(entry_item(1, 3, 32'h0003_0000));
    for (k = 0; k < 4; k++)
      push_item(data_item(rand_q16(), rand_q16()));
  endtask

  // random vectors with matrix writes and length changes mixed in
  task automatic test_random(input int target);
    int base;
    int dist_base;
    base = items_sent;
    dist_base = distance_count;
    while (items_sent - base < target || distance_count - dist_base < 40) begin
      if ($urandom_range(0, 2) == 0) write_length(pick_length());
      do begin
        if ($urandom_range(0, 5) == 0)
          push_item(entry_item($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                               rand_q16()));
        push_item(data_item(rand_q16(), rand_q16()));
        if (elem_idx != 0 && $urandom_range(0, 24) == 0)
          write_length(LW'($urandom_range(1, 12)));
      end while (elem_idx != 0);
      if ($urandom_range(0, 7) == 0) wait_drained(0);
    end
  endtask

  // test sequence
  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    len_reg = csic_pkg::VL_RESET;
    elem_idx = 0;
    sat_seen = 1'b0;
    errors = 0;
    cycles = 0;
    calm_left = 0;
    items_sent = 0;
    matrix_items = 0;
    data_items = 0;
    distance_count = 0;
    overflow_count = 0;
    lengths_written = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_fill_matrix();
    test_full_vector();
    test_length_extremes();
    test_difference_saturation();
    test_sum_saturation();
    test_length_lowered();
    test_length_raised();
    test_random(180);

    // let any stray result show up after the last one expected
    wait_drained(TEST_SIDE * TEST_SIDE + 100);
    $display("run covered %0d items: %0d matrix writes, %0d data elements, %0d length writes",
             items_sent, matrix_items, data_items, lengths_written);
    $display("checked %0d distances, %0d of them flagged overflow, %0d mismatches",
             distance_count, overflow_count, errors);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/csic_pkg.sv
rtl/core/csic_cell.sv
rtl/core/csic_term.sv
rtl/core/chi_square_inverse_covariance.sv
bench/testbench.sv
